### hdl/msqsd_pkg.sv
// ----------------------------------------------------------------------------
// msqsd_pkg
// Shared types and codes of the media send queue with selective drop.
// ----------------------------------------------------------------------------
package msqsd_pkg;

  // input function codes
  localparam logic [2:0] FUNC_VIDEO    = 3'd0;
  localparam logic [2:0] FUNC_AUDIO    = 3'd1;
  localparam logic [2:0] FUNC_CRITICAL = 3'd2;
  localparam logic [2:0] FUNC_DEQUEUE  = 3'd3;
  localparam logic [2:0] FUNC_PLAY     = 3'd4;

  // result outcome codes
  localparam logic [2:0] OUT_QUEUED  = 3'd0;
  localparam logic [2:0] OUT_DROPPED = 3'd1;
  localparam logic [2:0] OUT_GATED   = 3'd2;
  localparam logic [2:0] OUT_FULL    = 3'd3;
  localparam logic [2:0] OUT_DEQUEUE = 3'd4;
  localparam logic [2:0] OUT_EMPTY   = 3'd5;
  localparam logic [2:0] OUT_PLAY    = 3'd6;

  // entry class bits
  localparam logic [1:0] CLASS_AUDIO = 2'b00;
  localparam logic [1:0] CLASS_VIDEO = 2'b01;
  localparam int unsigned CLASS_KEY_BIT = 1;

  // back end operations
  localparam logic [1:0] OP_PASS = 2'd0;
  localparam logic [1:0] OP_ENQ  = 2'd1;
  localparam logic [1:0] OP_DEQ  = 2'd2;

  localparam logic [23:0] BYTE_LIMIT_RESET = 24'd1048576;

  // classified command from front to back
  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  outc;
    logic [23:0] bytes;
    logic [1:0]  cls;
    logic [31:0] ts;
  } cmd_t;

endpackage

### hdl/msqsd_ram.sv
// ----------------------------------------------------------------------------
// msqsd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module msqsd_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/msqsd_front.sv
// ----------------------------------------------------------------------------
// msqsd_front
// Accepts items, applies the play gate and timestamp rebase, and emits one
// classified command per beat.
// ----------------------------------------------------------------------------
module msqsd_front
  import msqsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [23:0] in_pkt_bytes,
  input  logic        in_is_key,
  input  logic        in_is_video,
  input  logic [31:0] in_timestamp,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  logic        playing_r, playing_nxt;
  logic        waiting_r, waiting_nxt;
  logic [31:0] base_r, base_nxt;
  logic        base_ok_r, base_ok_nxt;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // classify and rebase
  always_comb begin
    logic [31:0] b;
    logic        bv;
    playing_nxt = playing_r;
    waiting_nxt = waiting_r;
    base_nxt    = base_r;
    base_ok_nxt = base_ok_r;
    b           = base_r;
    bv          = base_ok_r;
    q_cmd.op    = OP_PASS;
    q_cmd.outc  = OUT_GATED;
    q_cmd.bytes = in_pkt_bytes;
    q_cmd.cls   = CLASS_AUDIO;
    q_cmd.ts    = '0;
    unique case (in_func)
      FUNC_VIDEO: begin
        if (playing_r && (!waiting_r || in_is_key)) begin
          if (waiting_r) begin
            waiting_nxt = 1'b0;
            b           = in_timestamp;
            bv          = 1'b1;
          end
          if (!bv) begin
            b  = in_timestamp;
            bv = 1'b1;
          end
          base_nxt    = b;
          base_ok_nxt = bv;
          q_cmd.op    = OP_ENQ;
          q_cmd.cls   = {in_is_key, 1'b1};
          q_cmd.ts    = (in_timestamp >= b) ? in_timestamp - b : '0;
        end
      end
      FUNC_AUDIO: begin
        if (playing_r && !waiting_r) begin
          if (!bv) begin
            b  = in_timestamp;
            bv = 1'b1;
          end
          base_nxt    = b;
          base_ok_nxt = bv;
          q_cmd.op    = OP_ENQ;
          q_cmd.cls   = CLASS_AUDIO;
          q_cmd.ts    = (in_timestamp >= b) ? in_timestamp - b : '0;
        end
      end
      FUNC_CRITICAL: begin
        q_cmd.op  = OP_ENQ;
        q_cmd.cls = {1'b1, in_is_video};
        q_cmd.ts  = in_timestamp;
      end
      FUNC_DEQUEUE: begin
        q_cmd.op = OP_DEQ;
      end
      FUNC_PLAY: begin
        playing_nxt = 1'b1;
        waiting_nxt = 1'b1;
        q_cmd.outc  = OUT_PLAY;
      end
      default: begin
        q_cmd.outc = OUT_GATED;
      end
    endcase
  end

  // gate state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      playing_r <= 1'b0;
      waiting_r <= 1'b0;
      base_r    <= '0;
      base_ok_r <= 1'b0;
    end else if (q_push) begin
      playing_r <= playing_nxt;
      waiting_r <= waiting_nxt;
      base_r    <= base_nxt;
      base_ok_r <= base_ok_nxt;
    end
  end

endmodule

### hdl/msqsd_cmdq.sv
// ----------------------------------------------------------------------------
// msqsd_cmdq
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module msqsd_cmdq
  import msqsd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic nempty,
  input  logic pop,
  output cmd_t head_cmd
);

  cmd_t       slot_r [2];
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign nempty   = (cnt_r != 2'd0);
  assign head_cmd = slot_r[0];

  // occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // slots, shift on pop
  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && cnt_r == 2'd1) begin
        slot_r[0] <= push_cmd;
      end else begin
        slot_r[0] <= slot_r[1];
        if (push) slot_r[1] <= push_cmd;
      end
    end else if (push) begin
      if (cnt_r == 2'd0) slot_r[0] <= push_cmd;
      else slot_r[1] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("command queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> nempty) else $error("command queue underflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("command queue count out of range");

endmodule

### hdl/msqsd_back.sv
// ----------------------------------------------------------------------------
// msqsd_back
// Executes commands on the circular entry store: enqueue with eviction scans,
// dequeue, and pass-through results. Holds the budget register.
// ----------------------------------------------------------------------------
module msqsd_back
  import msqsd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata,
  input  logic        q_nempty,
  output logic        q_pop,
  input  cmd_t        q_cmd,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_outcome,
  output logic [31:0] out_out_timestamp,
  output logic [8:0]  out_evicted_video,
  output logic [8:0]  out_evicted_audio,
  output logic        out_keyframe_request,
  output logic [23:0] out_popped_bytes,
  output logic [31:0] out_queued_total
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = AW + 1;
  localparam int QW = 25 + AW;
  localparam int EW = (CW > 9) ? CW : 9;
  localparam int TW = (QW > 33) ? QW : 33;
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [AW+1:0] DEPTH_W = (AW + 2)'(QUEUE_DEPTH);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_DEQ    = 3'd3;

  // store address wrap: head plus offset, modulo depth
  function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] h,
                                               input logic [CW-1:0] o);
    logic [AW+1:0] s;
    s = {2'b00, h} + {1'b0, o};
    if (s >= DEPTH_W) s = s - DEPTH_W;
    return s[AW-1:0];
  endfunction

  // saturate an eviction count to the nine-bit field
  function automatic logic [8:0] sat9(input logic [CW-1:0] n);
    logic [EW-1:0] e;
    e = EW'(n);
    return (e > EW'(511)) ? 9'd511 : e[8:0];
  endfunction

  logic [2:0]    st_r, st_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic [23:0]   limit_r;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [QW-1:0] qb_r, qb_nxt;
  logic [CW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] wr_r, wr_nxt;
  logic          pv_r, pv_nxt;
  logic          aud_r, aud_nxt;
  logic [CW-1:0] evv_r, evv_nxt;
  logic [CW-1:0] eva_r, eva_nxt;
  logic          ov_r, ov_nxt;

  logic [2:0]    o_outc_r, o_outc_nxt;
  logic [31:0]   o_ts_r, o_ts_nxt;
  logic [8:0]    o_ev_r, o_ev_nxt;
  logic [8:0]    o_ea_r, o_ea_nxt;
  logic          o_kr_r, o_kr_nxt;
  logic [23:0]   o_pop_r, o_pop_nxt;
  logic [31:0]   o_qt_r, o_qt_nxt;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [25:0]   ram_wdata, ram_rdata;

  msqsd_ram #(.WIDTH(26), .DEPTH(QUEUE_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer
  always_comb begin
    logic          over;
    logic          issue;
    logic [1:0]    want;
    logic [TW-1:0] qt;
    st_nxt     = st_r;
    cmd_nxt    = cmd_r;
    head_nxt   = head_r;
    cnt_nxt    = cnt_r;
    qb_nxt     = qb_r;
    rd_nxt     = rd_r;
    wr_nxt     = wr_r;
    pv_nxt     = 1'b0;
    aud_nxt    = aud_r;
    evv_nxt    = evv_r;
    eva_nxt    = eva_r;
    ov_nxt     = ov_r;
    o_outc_nxt = o_outc_r;
    o_ts_nxt   = o_ts_r;
    o_ev_nxt   = o_ev_r;
    o_ea_nxt   = o_ea_r;
    o_kr_nxt   = o_kr_r;
    o_pop_nxt  = o_pop_r;
    o_qt_nxt   = o_qt_r;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    q_pop      = 1'b0;
    over       = (qb_r + QW'(cmd_r.bytes)) > QW'(limit_r);
    issue      = 1'b0;
    want       = aud_r ? CLASS_AUDIO : CLASS_VIDEO;
    qt         = '0;
    unique case (st_r)
      ST_IDLE: begin
        if (q_nempty && !out_valid) begin
          q_pop      = 1'b1;
          cmd_nxt    = q_cmd;
          o_outc_nxt = q_cmd.outc;
          o_ts_nxt   = q_cmd.ts;
          o_ev_nxt   = '0;
          o_ea_nxt   = '0;
          o_kr_nxt   = 1'b0;
          o_pop_nxt  = '0;
          evv_nxt    = '0;
          eva_nxt    = '0;
          rd_nxt     = '0;
          wr_nxt     = '0;
          aud_nxt    = 1'b0;
          unique case (q_cmd.op)
            OP_ENQ: begin
              if ((qb_r + QW'(q_cmd.bytes)) > QW'(limit_r)) st_nxt = ST_SCAN;
              else st_nxt = ST_DECIDE;
            end
            OP_DEQ: begin
              if (cnt_r == '0) begin
                o_outc_nxt = OUT_EMPTY;
                ov_nxt     = 1'b1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = head_r;
                st_nxt    = ST_DEQ;
              end
            end
            default: begin
              ov_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // issue next read
        issue = (rd_r < cnt_r);
        if (issue) begin
          ram_re    = 1'b1;
          ram_raddr = wrap_addr(head_r, rd_r);
          rd_nxt    = rd_r + 1'b1;
        end
        pv_nxt = issue;
        // keep or evict the entry that came back
        if (pv_r) begin
          if (over && (ram_rdata[1:0] == want)) begin
            qb_nxt = qb_r - QW'(ram_rdata[25:2]);
            if (aud_r) eva_nxt = eva_r + 1'b1;
            else evv_nxt = evv_r + 1'b1;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = wrap_addr(head_r, wr_r);
            ram_wdata = ram_rdata;
            wr_nxt    = wr_r + 1'b1;
          end
        end
        // pass done
        if (!issue && !pv_r) begin
          cnt_nxt = wr_r;
          rd_nxt  = '0;
          wr_nxt  = '0;
          if (!aud_r && over) aud_nxt = 1'b1;
          else st_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        o_ev_nxt = sat9(evv_r);
        o_ea_nxt = sat9(eva_r);
        o_kr_nxt = (evv_r != '0);
        if (over && !cmd_r.cls[CLASS_KEY_BIT]) begin
          o_outc_nxt = OUT_DROPPED;
        end else if (cnt_r >= DEPTH_C) begin
          o_outc_nxt = OUT_FULL;
        end else begin
          ram_we     = 1'b1;
          ram_waddr  = wrap_addr(head_r, cnt_r);
          ram_wdata  = {cmd_r.bytes, cmd_r.cls};
          cnt_nxt    = cnt_r + 1'b1;
          qb_nxt     = qb_r + QW'(cmd_r.bytes);
          o_outc_nxt = OUT_QUEUED;
        end
        ov_nxt = 1'b1;
        st_nxt = ST_IDLE;
      end
      ST_DEQ: begin
        head_nxt   = wrap_addr(head_r, CW'(1));
        cnt_nxt    = cnt_r - 1'b1;
        qb_nxt     = (qb_r >= QW'(ram_rdata[25:2])) ? qb_r - QW'(ram_rdata[25:2]) : '0;
        o_pop_nxt  = ram_rdata[25:2];
        o_outc_nxt = OUT_DEQUEUE;
        ov_nxt     = 1'b1;
        st_nxt     = ST_IDLE;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
    // result handshake and saturated byte total
    if (ov_r && out_ready) ov_nxt = 1'b0;
    qt       = TW'(qb_nxt);
    o_qt_nxt = (qt > TW'(33'h0_FFFF_FFFF)) ? 32'hFFFF_FFFF : qt[31:0];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      head_r  <= '0;
      cnt_r   <= '0;
      qb_r    <= '0;
      pv_r    <= 1'b0;
      ov_r    <= 1'b0;
      limit_r <= BYTE_LIMIT_RESET;
      o_qt_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
      qb_r   <= qb_nxt;
      pv_r   <= pv_nxt;
      ov_r   <= ov_nxt;
      o_qt_r <= o_qt_nxt;
      if (cfg_we) limit_r <= cfg_wdata;
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    rd_r     <= rd_nxt;
    wr_r     <= wr_nxt;
    aud_r    <= aud_nxt;
    evv_r    <= evv_nxt;
    eva_r    <= eva_nxt;
    o_outc_r <= o_outc_nxt;
    o_ts_r   <= o_ts_nxt;
    o_ev_r   <= o_ev_nxt;
    o_ea_r   <= o_ea_nxt;
    o_kr_r   <= o_kr_nxt;
    o_pop_r  <= o_pop_nxt;
  end

  assign out_valid            = ov_r;
  assign out_outcome          = o_outc_r;
  assign out_out_timestamp    = o_ts_r;
  assign out_evicted_video    = o_ev_r;
  assign out_evicted_audio    = o_ea_r;
  assign out_keyframe_request = o_kr_r;
  assign out_popped_bytes     = o_pop_r;
  assign out_queued_total     = o_qt_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C) else $error("entry count above depth");
  a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_IDLE) |-> !ov_r) else $error("result pending while busy");
  a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SCAN && pv_r) |-> (wr_r < rd_r)) else $error("compaction overran reads");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (st_r == ST_IDLE && !ov_r)) else $error("command taken while busy");

endmodule

### hdl/media_send_queue_selective_drop.sv
// ----------------------------------------------------------------------------
// media_send_queue_selective_drop
// Per-client media send queue with byte budget and selective discard.
// ----------------------------------------------------------------------------
// Usage: items enter on the in_ channel (valid/ready), one result per item
// leaves on the out_ channel (valid/ready). cfg_we/cfg_wdata set the byte
// budget; write it only while the block is idle.
// The front gates and rebases items and hands them through a two-entry
// command queue to the back, which owns the circular entry store (one RAM,
// registered read) and the byte total.
// Per item: pass-through results (gated, play, empty) are registered as the
// back takes the command; a dequeue first reads the head entry; an enqueue
// that fits passes the decide state. Over budget, it scans the store once
// for video and, if still over, once for audio, rewriting kept entries.
// Items are worked one at a time in the back; the front keeps accepting
// while the command queue has room.
// Reset clears counters, pointers, the play gate and sets the budget to
// 1048576; store contents need no clearing. A stalled receiver holds the
// result; the back then stops taking commands and the front fills the
// queue before it drops in_ready.
// ----------------------------------------------------------------------------
module media_send_queue_selective_drop
  import msqsd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [23:0] in_pkt_bytes,
  input  logic        in_is_key,
  input  logic        in_is_video,
  input  logic [31:0] in_timestamp,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_outcome,
  output logic [31:0] out_out_timestamp,
  output logic [8:0]  out_evicted_video,
  output logic [8:0]  out_evicted_audio,
  output logic        out_keyframe_request,
  output logic [23:0] out_popped_bytes,
  output logic [31:0] out_queued_total
);

  logic q_full, q_push, q_nempty, q_pop;
  cmd_t push_cmd, head_cmd;

  // front: gate and classify
  msqsd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_pkt_bytes (in_pkt_bytes),
    .in_is_key    (in_is_key),
    .in_is_video  (in_is_video),
    .in_timestamp (in_timestamp),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  // decoupling queue
  msqsd_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .nempty   (q_nempty),
    .pop      (q_pop),
    .head_cmd (head_cmd)
  );

  // back: store and eviction
  msqsd_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .q_nempty             (q_nempty),
    .q_pop                (q_pop),
    .q_cmd                (head_cmd),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_outcome          (out_outcome),
    .out_out_timestamp    (out_out_timestamp),
    .out_evicted_video    (out_evicted_video),
    .out_evicted_audio    (out_evicted_audio),
    .out_keyframe_request (out_keyframe_request),
    .out_popped_bytes     (out_popped_bytes),
    .out_queued_total     (out_queued_total)
  );

endmodule
